FILE: rtl/core/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
package uer_pkg;

   // register and field widths
   localparam int unsigned DATA_WIDTH   = 16;
   localparam int unsigned CSR_IDX_BITS = 3;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HOLDOFF_US        = 3'd0,
      CSR_TRIGGER_US        = 3'd1,
      CSR_ECHO_TIMEOUT_US   = 3'd2,
      CSR_SCALE_Q16         = 3'd3,
      CSR_NEAR_THRESHOLD_CM = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [DATA_WIDTH-1:0] HOLDOFF_US_RESET        = 16'd200;
   localparam logic [DATA_WIDTH-1:0] TRIGGER_US_RESET        = 16'd5;
   localparam logic [DATA_WIDTH-1:0] ECHO_TIMEOUT_US_RESET   = 16'd50;
   // 344.8 m/s round trip in cm per us, times 65536
   localparam logic [DATA_WIDTH-1:0] SCALE_Q16_RESET         = 16'd1130;
   localparam logic [DATA_WIDTH-1:0] NEAR_THRESHOLD_CM_RESET = 16'd100;

   // counter saturation and distance cap
   localparam logic [DATA_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [DATA_WIDTH-1:0] DIST_CAP  = 16'hFFFE;

   // ranging cycle phases
   typedef enum logic [1:0] {
      PH_HOLDOFF = 2'd0,
      PH_TRIGGER = 2'd1,
      PH_WAIT    = 2'd2,
      PH_MEASURE = 2'd3
   } phase_type;

endpackage

FILE: rtl/core/uer_if.sv
// item channel interfaces for the ultrasonic echo ranger
interface uer_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           drive_enable;
   logic                           drive_level;
   logic                           done_res;
   logic                           no_object;
   logic [uer_pkg::DATA_WIDTH-1:0] distance_cm;
   logic                           near;

   modport source (output valid, output drive_enable, output drive_level, output done_res,
                   output no_object, output distance_cm, output near, input ready);
   modport sink   (input valid, input drive_enable, input drive_level, input done_res,
                   input no_object, input distance_cm, input near, output ready);
endinterface

FILE: rtl/core/ultrasonic_echo_ranger_unit.sv
// top level of the ultrasonic echo ranger: ranging cycle sequencer and distance scaling
// a tick item is held in the input register and its result item in the result register
// throughput: one tick item per cycle while result items are taken, set by the phase update between
//    the input register and the result register
// reset (synchronous, active high): phase to holdoff, elapsed count and near flag
//    to zero, registers to their default values, both item stages empty
module ultrasonic_echo_ranger_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   uer_req_if.sink                              req_if,
   uer_rsp_if.source                            rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [uer_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [uer_pkg::DATA_WIDTH-1:0]       csr_write_data
);

   // configuration registers
   logic [uer_pkg::DATA_WIDTH-1:0] holdoff_ff;
   logic [uer_pkg::DATA_WIDTH-1:0] trigger_ff;
   logic [uer_pkg::DATA_WIDTH-1:0] timeout_ff;
   logic [uer_pkg::DATA_WIDTH-1:0] scale_ff;
   logic [uer_pkg::DATA_WIDTH-1:0] threshold_ff;

   // input stage
   logic                           in_valid_ff;
   logic                           in_echo_ff;

   // ranging state
   uer_pkg::phase_type             phase_ff;
   uer_pkg::phase_type             phase_in;
   logic [uer_pkg::DATA_WIDTH-1:0] elapsed_ff;
   logic [uer_pkg::DATA_WIDTH-1:0] elapsed_in;
   logic                           near_ff;
   logic                           near_in;

   // result stage
   logic                           out_valid_ff;
   logic                           den_ff,   den_in;
   logic                           dlv_ff,   dlv_in;
   logic                           done_ff,  done_in;
   logic                           noobj_ff, noobj_in;
   logic [uer_pkg::DATA_WIDTH-1:0] dist_ff,  dist_in;

   // working values
   uer_pkg::phase_type             ph_start;
   logic [uer_pkg::DATA_WIDTH-1:0] el_start;
   logic [uer_pkg::DATA_WIDTH-1:0] el_inc;
   logic [2*uer_pkg::DATA_WIDTH-1:0] product;
   logic [uer_pkg::DATA_WIDTH-1:0] cm_raw;
   logic [uer_pkg::DATA_WIDTH-1:0] cm_capped;
   logic                           advance;

   // pipeline flow: the stage moves when the result slot is free or being taken
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff   <= uer_pkg::HOLDOFF_US_RESET;
         trigger_ff   <= uer_pkg::TRIGGER_US_RESET;
         timeout_ff   <= uer_pkg::ECHO_TIMEOUT_US_RESET;
         scale_ff     <= uer_pkg::SCALE_Q16_RESET;
         threshold_ff <= uer_pkg::NEAR_THRESHOLD_CM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            uer_pkg::CSR_HOLDOFF_US:        holdoff_ff   <= csr_write_data;
            uer_pkg::CSR_TRIGGER_US:        trigger_ff   <= csr_write_data;
            uer_pkg::CSR_ECHO_TIMEOUT_US:   timeout_ff   <= csr_write_data;
            uer_pkg::CSR_SCALE_Q16:         scale_ff     <= csr_write_data;
            uer_pkg::CSR_NEAR_THRESHOLD_CM: threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_echo_ff <= req_if.echo_level;
      end
   end

   // distance scaling: Q0.16 multiply, truncate, cap
   assign product   = {{uer_pkg::DATA_WIDTH{1'b0}}, elapsed_ff}
                    * {{uer_pkg::DATA_WIDTH{1'b0}}, scale_ff};
   assign cm_raw    = product[2*uer_pkg::DATA_WIDTH-1:uer_pkg::DATA_WIDTH];
   assign cm_capped = (cm_raw > uer_pkg::DIST_CAP) ? uer_pkg::DIST_CAP : cm_raw;

   // phase skip for expired holdoff and trigger, then this tick's work
   always_comb begin
      ph_start = phase_ff;
      el_start = elapsed_ff;
      if (ph_start == uer_pkg::PH_HOLDOFF && el_start >= holdoff_ff) begin
         ph_start = uer_pkg::PH_TRIGGER;
         el_start = '0;
      end
      if (ph_start == uer_pkg::PH_TRIGGER && el_start >= trigger_ff) begin
         ph_start = uer_pkg::PH_WAIT;
         el_start = '0;
      end
      el_inc = (el_start == uer_pkg::COUNT_MAX) ? el_start
                                                : el_start + uer_pkg::DATA_WIDTH'(1);

      phase_in   = ph_start;
      elapsed_in = el_inc;
      near_in    = near_ff;
      den_in     = 1'b0;
      dlv_in     = 1'b0;
      done_in    = 1'b0;
      noobj_in   = 1'b0;
      dist_in    = '0;

      case (ph_start)
         uer_pkg::PH_HOLDOFF: begin
         end
         uer_pkg::PH_TRIGGER: begin
            den_in = 1'b1;
            dlv_in = 1'b1;
         end
         uer_pkg::PH_WAIT: begin
            if (in_echo_ff) begin
               phase_in   = uer_pkg::PH_MEASURE;
               elapsed_in = uer_pkg::DATA_WIDTH'(1);
            end else if (el_inc >= timeout_ff) begin
               done_in    = 1'b1;
               noobj_in   = 1'b1;
               phase_in   = uer_pkg::PH_HOLDOFF;
               elapsed_in = '0;
            end
         end
         uer_pkg::PH_MEASURE: begin
            // measure is never skipped into, so elapsed_ff is the echo width here
            if (!in_echo_ff) begin
               dist_in    = cm_capped;
               done_in    = 1'b1;
               near_in    = (cm_capped < threshold_ff);
               phase_in   = uer_pkg::PH_HOLDOFF;
               elapsed_in = '0;
            end
         end
         default: begin
            phase_in   = uer_pkg::PH_HOLDOFF;
            elapsed_in = '0;
         end
      endcase
   end

   // ranging state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uer_pkg::PH_HOLDOFF;
         elapsed_ff   <= '0;
         near_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            near_ff    <= near_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff   <= den_in;
         dlv_ff   <= dlv_in;
         done_ff  <= done_in;
         noobj_ff <= noobj_in;
         dist_ff  <= dist_in;
      end
   end

   // result channel
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.drive_enable = den_ff;
   assign rsp_if.drive_level  = dlv_ff;
   assign rsp_if.done_res     = done_ff;
   assign rsp_if.no_object    = noobj_ff;
   assign rsp_if.distance_cm  = dist_ff;
   assign rsp_if.near         = near_ff;

endmodule

FILE: rtl/core/uer_checker.sv
// port checker for the ultrasonic echo ranger and its bind
module uer_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_drive_enable,
   input logic                           rsp_drive_level,
   input logic                           rsp_done_res,
   input logic                           rsp_no_object,
   input logic [uer_pkg::DATA_WIDTH-1:0] rsp_distance_cm
);

   // the line is only driven high: drive level always equals drive enable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_level == rsp_drive_enable))
      else $error("drive level and drive enable disagree");

   // a finishing tick never drives the line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_drive_enable)
      else $error("cycle finished during trigger");

   // no object and distance only come with a finished cycle, and no object has no distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_done_res || rsp_no_object) |->
         (rsp_distance_cm == '0) && (rsp_done_res || !rsp_no_object))
      else $error("distance or no object outside a finished cycle");

   // capped distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance_cm != uer_pkg::COUNT_MAX))
      else $error("distance above cap");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_cm)
         && $stable(rsp_done_res) && $stable(rsp_no_object))
      else $error("stalled result item changed");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_drive_enable (rsp_if.drive_enable),
   .rsp_drive_level  (rsp_if.drive_level),
   .rsp_done_res     (rsp_if.done_res),
   .rsp_no_object    (rsp_if.no_object),
   .rsp_distance_cm  (rsp_if.distance_cm)
);

FILE: dv/tb_top.sv
// testbench for the ultrasonic echo ranger: directed and random tick streams, checked per result
`timescale 1ns / 100ps

module tb_top;
   import uer_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 6000000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned ERROR_PRINTS = 40;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned RANDOM_SETS  = 6;
   localparam int unsigned SET_TICKS    = 60;

   // one result item as the ranger should emit it
   typedef struct packed {
      logic                  drive_enable;
      logic                  drive_level;
      logic                  done_res;
      logic                  no_object;
      logic [DATA_WIDTH-1:0] distance_cm;
      logic                  near;
   } echo_report_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DATA_WIDTH-1:0]   csr_write_data;

   uer_req_if req_ch();
   uer_rsp_if rsp_ch();

   ultrasonic_echo_ranger_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ranging state mirrored by the predictor
   phase_type             rng_phase;
   logic [DATA_WIDTH-1:0] rng_elapsed;
   logic                  rng_near;
   logic [DATA_WIDTH-1:0] cfg_holdoff;
   logic [DATA_WIDTH-1:0] cfg_trigger;
   logic [DATA_WIDTH-1:0] cfg_echo_timeout;
   logic [DATA_WIDTH-1:0] cfg_scale;
   logic [DATA_WIDTH-1:0] cfg_near_threshold;

   echo_report_type pending_reports[$];
   echo_report_type want;

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned reports_checked;
   int unsigned ranged_count;
   int unsigned no_object_count;
   int unsigned cycle_count;
   int unsigned burst_left;
   bit          no_gaps;
   bit          hold_request;
   int unsigned hold_left;
   int unsigned stall_mode;
   int unsigned mode_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                  pending_reports.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [DATA_WIDTH-1:0] sat_step(input logic [DATA_WIDTH-1:0] count);
      return (count == COUNT_MAX) ? count : count + 1'b1;
   endfunction

   // advance the ranging cycle by one tick and return the expected result item
   function automatic echo_report_type ranger_advance(input logic echo);
      echo_report_type       r;
      logic [31:0]           product;
      logic [DATA_WIDTH-1:0] cm;
      r = '0;
      if (rng_phase == PH_HOLDOFF && rng_elapsed >= cfg_holdoff) begin
         rng_phase   = PH_TRIGGER;
         rng_elapsed = '0;
      end
      if (rng_phase == PH_TRIGGER && rng_elapsed >= cfg_trigger) begin
         rng_phase   = PH_WAIT;
         rng_elapsed = '0;
      end
      case (rng_phase)
         PH_HOLDOFF: rng_elapsed = sat_step(rng_elapsed);
         PH_TRIGGER: begin
            r.drive_enable = 1'b1;
            r.drive_level  = 1'b1;
            rng_elapsed    = sat_step(rng_elapsed);
         end
         PH_WAIT: begin
            if (echo) begin
               rng_phase   = PH_MEASURE;
               rng_elapsed = 16'd1;
            end else begin
               rng_elapsed = sat_step(rng_elapsed);
               // a zero timeout behaves like one
               if (rng_elapsed >= cfg_echo_timeout) begin
                  r.done_res  = 1'b1;
                  r.no_object = 1'b1;
                  rng_phase   = PH_HOLDOFF;
                  rng_elapsed = '0;
               end
            end
         end
         default: begin
            if (echo) begin
               rng_elapsed = sat_step(rng_elapsed);
            end else begin
               product       = {16'd0, rng_elapsed} * {16'd0, cfg_scale};
               cm            = (product[31:16] > DIST_CAP) ? DIST_CAP : product[31:16];
               r.distance_cm = cm;
               r.done_res    = 1'b1;
               rng_near      = (cm < cfg_near_threshold);
               rng_phase     = PH_HOLDOFF;
               rng_elapsed   = '0;
            end
         end
      endcase
      r.near = rng_near;
      return r;
   endfunction

   // true when the next tick falls in the echo wait
   function automatic bit wait_starts_next();
      return (rng_phase == PH_WAIT) ||
             (rng_phase == PH_TRIGGER && rng_elapsed >= cfg_trigger) ||
             (rng_phase == PH_HOLDOFF && rng_elapsed >= cfg_holdoff && cfg_trigger == '0);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned expected);
      error_count++;
      if (error_count <= ERROR_PRINTS)
         $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, expected);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("result item with nothing pending, done_res", rsp_ch.done_res, 0);
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (want.done_res && want.no_object) no_object_count++;
            else if (want.done_res) ranged_count++;
            if (rsp_ch.drive_enable !== want.drive_enable)
               report_mismatch("drive_enable", rsp_ch.drive_enable, want.drive_enable);
            if (rsp_ch.drive_level !== want.drive_level)
               report_mismatch("drive_level", rsp_ch.drive_level, want.drive_level);
            if (rsp_ch.done_res !== want.done_res)
               report_mismatch("done_res", rsp_ch.done_res, want.done_res);
            if (rsp_ch.no_object !== want.no_object)
               report_mismatch("no_object", rsp_ch.no_object, want.no_object);
            if (rsp_ch.distance_cm !== want.distance_cm)
               report_mismatch("distance_cm", rsp_ch.distance_cm, want.distance_cm);
            if (rsp_ch.near !== want.near)
               report_mismatch("near", rsp_ch.near, want.near);
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      mode_left    = 0;
      stall_mode   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(10, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_ch.ready = 1'b1;
               1:       rsp_ch.ready = 1'($urandom_range(0, 1));
               2:       rsp_ch.ready = ($urandom_range(0, 9) != 0);
               default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // send one tick item in bursts with random gaps, predict on acceptance
   task automatic send_tick(input logic echo);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid      = 1'b0;
            req_ch.echo_level = 1'($urandom_range(0, 1));
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.echo_level = echo;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_reports.push_back(ranger_advance(echo));
      items_sent++;
   endtask

   // stop sending and wait until every pending result is back
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      case (idx)
         CSR_HOLDOFF_US:        cfg_holdoff        = value;
         CSR_TRIGGER_US:        cfg_trigger        = value;
         CSR_ECHO_TIMEOUT_US:   cfg_echo_timeout   = value;
         CSR_SCALE_Q16:         cfg_scale          = value;
         CSR_NEAR_THRESHOLD_CM: cfg_near_threshold = value;
         default: ;
      endcase
   endtask

   // reprogram all registers while the block is idle
   task automatic set_ranging(input logic [DATA_WIDTH-1:0] holdoff,
                              input logic [DATA_WIDTH-1:0] trigger,
                              input logic [DATA_WIDTH-1:0] timeout,
                              input logic [DATA_WIDTH-1:0] scale,
                              input logic [DATA_WIDTH-1:0] threshold);
      drain_results();
      write_reg(CSR_HOLDOFF_US, holdoff);
      write_reg(CSR_TRIGGER_US, trigger);
      write_reg(CSR_ECHO_TIMEOUT_US, timeout);
      write_reg(CSR_SCALE_Q16, scale);
      write_reg(CSR_NEAR_THRESHOLD_CM, threshold);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // one well-formed ping: low until the wait starts, then delay lows, an echo, a low
   task automatic ping(input int unsigned delay, input int unsigned width);
      while (!wait_starts_next()) send_tick(1'b0);
      repeat (delay) send_tick(1'b0);
      repeat (width) send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // reset register values: one short echo, then a timeout
   task automatic test_default_cycle();
      ping(10, 30);
      ping(60, 1);
   endtask

   // zero holdoff, zero trigger and zero timeout, then trigger and timeout of one
   task automatic test_phase_skips();
      set_ranging(16'd0, 16'd0, 16'd0, 16'd1130, 16'd100);
      send_tick(1'b0);
      send_tick(1'b0);
      ping(0, 3);
      set_ranging(16'd0, 16'd1, 16'd1, 16'd40000, 16'd2);
      ping(0, 1);
      send_tick(1'b0);
      ping(0, 4);
   endtask

   // near flag against the threshold, held across no-object cycles, scale extremes
   task automatic test_near_flag();
      set_ranging(16'd1, 16'd1, 16'd8, 16'h8000, 16'd10);
      ping(2, 20);
      set_ranging(16'd1, 16'd1, 16'd8, 16'h8000, 16'd11);
      ping(0, 20);
      ping(20, 2);
      set_ranging(16'd1, 16'd1, 16'd8, 16'd0, 16'd0);
      ping(1, 5);
      set_ranging(16'd1, 16'd1, 16'd8, 16'd0, 16'hFFFF);
      ping(1, 5);
   endtask

   // longer holdoff, trigger and timeout, then wide echoes at full scale
   task automatic test_long_phases();
      set_ranging(16'd60, 16'd30, 16'd80, 16'd1130, 16'd100);
      ping(85, 0);
      set_ranging(16'd0, 16'd1, 16'd20, 16'hFFFF, 16'hFFFF);
      ping(3, 150);
      set_ranging(16'd0, 16'd1, 16'd20, 16'hFFFF, 16'd50);
      ping(3, 60);
   endtask

   // receiver holds off while items keep coming, so the block stalls its input
   task automatic test_backpressure();
      set_ranging(16'd2, 16'd1, 16'd6, 16'd9000, 16'd3);
      no_gaps      = 1'b1;
      hold_request = 1'b1;
      repeat (8) ping($urandom_range(0, 4), $urandom_range(1, 10));
      no_gaps = 1'b0;
   endtask

   // random pings and noise over several register settings
   task automatic test_random_ranging();
      int unsigned target;
      int unsigned width;
      for (int unsigned set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
         case (set_idx)
            0: set_ranging(16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd0);
            1: set_ranging(16'd3, 16'd2, 16'd12, 16'd0, 16'hFFFF);
            default: set_ranging(16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
                                 16'($urandom_range(0, 24)), 16'($urandom_range(0, 65535)),
                                 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 300)));
         endcase
         target = items_sent + SET_TICKS;
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
               width = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 400)
                                                   : $urandom_range(1, 40);
               ping($urandom_range(0, cfg_echo_timeout + 2), width);
            end else begin
               repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // sequence of tests
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.echo_level  = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      hold_request       = 1'b0;
      no_gaps            = 1'b0;
      burst_left         = 0;
      error_count        = 0;
      items_sent         = 0;
      reports_checked    = 0;
      ranged_count       = 0;
      no_object_count    = 0;
      rng_phase          = PH_HOLDOFF;
      rng_elapsed        = '0;
      rng_near           = 1'b0;
      cfg_holdoff        = HOLDOFF_US_RESET;
      cfg_trigger        = TRIGGER_US_RESET;
      cfg_echo_timeout   = ECHO_TIMEOUT_US_RESET;
      cfg_scale          = SCALE_Q16_RESET;
      cfg_near_threshold = NEAR_THRESHOLD_CM_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_cycle();
      test_phase_skips();
      test_near_flag();
      test_long_phases();
      test_backpressure();
      test_random_ranging();

      drain_results();
      $display("checked %0d result items from %0d tick items: %0d echoes ranged, %0d no-object",
               reports_checked, items_sent, ranged_count, no_object_count);
      $display("covered reset values, skipped phases, longer phases, full-scale echoes, stalls");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
